FILE: sv/bsm_pkg.sv
// Package for the bank switch mapper: item types, result kinds, decoded
// register addresses and bank command codes.
// No dependencies; every other file of the block imports it.
package bsm_pkg;

   // One input item: a bus write or a scanline tick.
   typedef struct packed {
      logic        func;
      logic [15:0] address;
      logic [7:0]  value;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] window_address;
      logic [8:0]  number;
      logic        flag;
      logic        last;
   } rsp_type;

   // Up to two results caused by one input item.
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } rsp_pair_type;

   // Result kinds.
   localparam logic [2:0] KIND_PRG    = 3'd0;
   localparam logic [2:0] KIND_CHR    = 3'd1;
   localparam logic [2:0] KIND_MIRROR = 3'd2;
   localparam logic [2:0] KIND_SAVE   = 3'd3;
   localparam logic [2:0] KIND_IRQ    = 3'd4;
   localparam logic [2:0] KIND_PASS   = 3'd5;
   localparam logic [2:0] KIND_NONE   = 3'd6;

   // Input item function codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // Decoded register addresses.
   localparam logic [15:0] ADDR_CMD_SELECT = 16'h8000;
   localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
   localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
   localparam logic [15:0] ADDR_SAVE_RAM   = 16'hA001;
   localparam logic [15:0] ADDR_IRQ_COUNT  = 16'hC000;
   localparam logic [15:0] ADDR_IRQ_LATCH  = 16'hC001;
   localparam logic [15:0] ADDR_IRQ_OFF    = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_ON     = 16'hE001;

   // Bank command codes.
   localparam logic [2:0] CMD_CHR_2K_0 = 3'd0;
   localparam logic [2:0] CMD_CHR_2K_1 = 3'd1;
   localparam logic [2:0] CMD_CHR_1K_0 = 3'd2;
   localparam logic [2:0] CMD_CHR_1K_1 = 3'd3;
   localparam logic [2:0] CMD_CHR_1K_2 = 3'd4;
   localparam logic [2:0] CMD_CHR_1K_3 = 3'd5;
   localparam logic [2:0] CMD_PRG_0    = 3'd6;
   localparam logic [2:0] CMD_PRG_1    = 3'd7;

   // Window base addresses.
   localparam logic [15:0] WIN_CHR_1K    = 16'h0400;
   localparam logic [15:0] WIN_CHR_FLIP  = 16'h1000;
   localparam logic [15:0] WIN_PRG_LOW   = 16'h8000;
   localparam logic [15:0] WIN_PRG_MID   = 16'hA000;
   localparam logic [15:0] WIN_PRG_HIGH  = 16'hC000;

   localparam logic [8:0] PRG_BANKS_RESET = 9'd32;

endpackage

FILE: sv/bsm_core.sv
// Mapper state and decode: holds the bank, mode and IRQ registers and turns
// the registered input item into one or two results.
// Depends on bsm_pkg.
module bsm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  bsm_pkg::req_type     item,
   input  logic                 advance,
   input  logic                 csr_write_enable,
   input  logic [8:0]           csr_write_data,
   output bsm_pkg::rsp_pair_type pair
);
   import bsm_pkg::*;

   logic [8:0]  prg_banks_ff;
   logic [2:0]  pending_ff, pending_in;
   logic        prg_mode_ff, prg_mode_in;
   logic        chr_mode_ff, chr_mode_in;
   logic        changed_ff, changed_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  reload_ff, reload_in;
   logic        irq_on_ff, irq_on_in;

   logic [8:0]  banks_m1;
   logic [8:0]  fixed_bank;
   logic [15:0] chr_flip;
   logic [8:0]  arg;
   logic [8:0]  even;
   rsp_type     fixed_rsp;
   rsp_type     none_rsp;

   // The fixed bank is the second-last 8K bank, wrapped to nine bits.
   assign banks_m1   = prg_banks_ff - 9'd1;
   assign fixed_bank = {banks_m1[7:0], 1'b0};
   assign chr_flip   = chr_mode_ff ? WIN_CHR_FLIP : 16'h0000;
   assign arg        = {1'b0, item.value};
   assign even       = {1'b0, item.value[7:1], 1'b0};

   always_comb begin
      none_rsp      = '0;
      none_rsp.kind = KIND_NONE;
      none_rsp.last = 1'b1;
      fixed_rsp                = '0;
      fixed_rsp.kind           = KIND_PRG;
      fixed_rsp.window_address = prg_mode_ff ? WIN_PRG_LOW : WIN_PRG_HIGH;
      fixed_rsp.number         = fixed_bank;
   end

   // Decode of the item and the next state.
   always_comb begin
      pair        = '0;
      pair.first  = none_rsp;
      pair.second = none_rsp;
      pending_in  = pending_ff;
      prg_mode_in = prg_mode_ff;
      chr_mode_in = chr_mode_ff;
      changed_in  = changed_ff;
      count_in    = count_ff;
      reload_in   = reload_ff;
      irq_on_in   = irq_on_ff;

      if (item.func == FUNC_TICK) begin
         if (irq_on_ff && count_ff == 9'd0) begin
            count_in        = {1'b0, reload_ff};
            pair.first.kind = KIND_IRQ;
         end else if (irq_on_ff) begin
            count_in = count_ff - 9'd1;
         end
      end else if (!item.address[15]) begin
         pair.first.kind           = KIND_PASS;
         pair.first.window_address = item.address;
         pair.first.number         = arg;
      end else begin
         unique case (item.address)
            ADDR_BANK_DATA: begin
               pair.first.kind  = KIND_CHR;
               pair.second.kind = KIND_CHR;
               unique case (pending_ff)
                  CMD_CHR_2K_0, CMD_CHR_2K_1: begin
                     pair.two                   = 1'b1;
                     pair.first.last            = 1'b0;
                     pair.first.window_address  = chr_flip ^
                        ((pending_ff == CMD_CHR_2K_1) ? 16'h0800 : 16'h0000);
                     pair.second.window_address = pair.first.window_address
                                                  ^ WIN_CHR_1K;
                     pair.first.number          = even;
                     pair.second.number         = even | 9'd1;
                  end
                  CMD_CHR_1K_0, CMD_CHR_1K_1, CMD_CHR_1K_2, CMD_CHR_1K_3: begin
                     pair.first.window_address = chr_flip ^
                        {4'b0001, pending_ff[1:0] - 2'd2, 10'd0};
                     pair.first.number         = arg;
                  end
                  CMD_PRG_0: begin
                     pair.first.kind = KIND_PRG;
                     if (changed_ff) begin
                        pair.two                   = 1'b1;
                        pair.first                 = fixed_rsp;
                        pair.first.last            = 1'b0;
                        pair.second.kind           = KIND_PRG;
                        pair.second.window_address =
                           prg_mode_ff ? WIN_PRG_HIGH : WIN_PRG_LOW;
                        pair.second.number         = arg;
                        changed_in                 = 1'b0;
                     end else begin
                        pair.first.window_address =
                           prg_mode_ff ? WIN_PRG_HIGH : WIN_PRG_LOW;
                        pair.first.number         = arg;
                     end
                  end
                  CMD_PRG_1: begin
                     pair.first.kind           = KIND_PRG;
                     pair.first.window_address = WIN_PRG_MID;
                     pair.first.number         = arg;
                     if (changed_ff) begin
                        pair.two         = 1'b1;
                        pair.first.last  = 1'b0;
                        pair.second      = fixed_rsp;
                        pair.second.last = 1'b1;
                        changed_in       = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            ADDR_MIRROR: begin
               pair.first.kind = KIND_MIRROR;
               pair.first.flag = item.value[0];
            end
            ADDR_SAVE_RAM: begin
               pair.first.kind = KIND_SAVE;
               pair.first.flag = item.value[0];
            end
            ADDR_CMD_SELECT: begin
               pending_in  = item.value[2:0];
               prg_mode_in = item.value[6];
               chr_mode_in = item.value[7];
               if (item.value[6] != prg_mode_ff) begin
                  changed_in = 1'b1;
               end
            end
            ADDR_IRQ_COUNT: count_in  = {1'b0, item.value};
            ADDR_IRQ_LATCH: reload_in = item.value;
            ADDR_IRQ_OFF:   irq_on_in = 1'b0;
            ADDR_IRQ_ON:    irq_on_in = 1'b1;
            default: ;
         endcase
      end
   end

   // Mode and IRQ registers advance when the item moves into the result queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_banks_ff <= PRG_BANKS_RESET;
         pending_ff   <= '0;
         prg_mode_ff  <= 1'b0;
         chr_mode_ff  <= 1'b0;
         changed_ff   <= 1'b0;
         count_ff     <= '0;
         reload_ff    <= '0;
         irq_on_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            prg_banks_ff <= csr_write_data;
         end
         if (advance) begin
            pending_ff  <= pending_in;
            prg_mode_ff <= prg_mode_in;
            chr_mode_ff <= chr_mode_in;
            changed_ff  <= changed_in;
            count_ff    <= count_in;
            reload_ff   <= reload_in;
            irq_on_ff   <= irq_on_in;
         end
      end
   end

endmodule

FILE: sv/bsm_rsp_queue.sv
// Two-entry result queue: takes one or two results of an item at once and
// hands them out one per cycle while rsp_ready is high.
// Depends on bsm_pkg.
module bsm_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  bsm_pkg::rsp_pair_type pair,
   input  logic                  push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bsm_pkg::rsp_type      rsp_data
);
   import bsm_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;
   logic [1:0] after_pop;
   logic [1:0] needed;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign after_pop = count_ff - {1'b0, pop};
   assign needed    = pair.two ? 2'd2 : 2'd1;

   // The item fits when its results fit beside what stays after this pop.
   assign room = ({1'b0, after_pop} + {1'b0, needed}) <= 3'd2;

   // Pop shifts the second entry down; push appends after what is left.
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         count_in = after_pop;
      end
      if (push) begin
         if (pair.two) begin
            slot0_in = pair.first;
            slot1_in = pair.second;
            count_in = 2'd2;
         end else begin
            if (after_pop == 2'd0) begin
               slot0_in = pair.first;
            end else begin
               slot1_in = pair.first;
            end
            count_in = after_pop + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

FILE: sv/bank_switch_mapper_with_scanline_irq.sv
// Top level of the bank switch mapper with scanline IRQ counter.
// Depends on bsm_pkg, bsm_core and bsm_rsp_queue.
//
//   Channel  Direction  Handshake                  Carries
//   req_     in         req_valid / req_ready      bus write or scanline tick
//   rsp_     out        rsp_valid / rsp_ready      bank load, IRQ, passthrough
//   csr_     in         csr_write_enable           PRG 16K bank count
//
// An item is registered on acceptance and decoded in the following cycle,
// moving into a two-entry result queue; the first result shows when the
// queue takes it. One-result items sustain one item per cycle while
// rsp_ready is high; a bank command's two results leave one after the
// other through the single result port. Reset clears the mapper registers,
// empties the queue and sets the bank count to 32. A stalled rsp_ready
// holds the queue and, lacking room, the input register: req_ready drops.
module bank_switch_mapper_with_scanline_irq (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsm_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [8:0]       csr_write_data
);
   import bsm_pkg::*;

   logic         in_valid_ff;
   req_type      in_item_ff;
   logic         advance;
   logic         room;
   rsp_pair_type pair;

   // Input register: refills when empty or when its item moves on.
   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   bsm_core u_core (
      .clock            (clock),
      .reset            (reset),
      .item             (in_item_ff),
      .advance          (advance),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pair             (pair)
   );

   bsm_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .push      (advance),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/bsm_checker.sv
// Port-level checks for the bank switch mapper, bound to the top level.
// Depends on bsm_pkg and bank_switch_mapper_with_scanline_irq.
module bsm_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bsm_pkg::rsp_type rsp_data
);
   import bsm_pkg::*;

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // The queue is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only bank loads are followed by a second result of the same item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |->
         rsp_data.kind == KIND_PRG || rsp_data.kind == KIND_CHR)
      else $error("non-final result is not a bank load");

   // The second result of an item is queued with the first.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("second result of an item missing");

   // Results that carry no window or bank have them cleared.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_IRQ || rsp_data.kind == KIND_NONE) |->
         rsp_data.window_address == 16'h0000 && rsp_data.number == 9'd0 &&
         !rsp_data.flag)
      else $error("result without effect carries data");

endmodule

bind bank_switch_mapper_with_scanline_irq bsm_checker u_checker (.*);
